// ===== hw/rtl/lcs_pkg.sv =====
`timescale 1ns / 1ps

package lcs_pkg;

    // Operation codes carried by one input beat.
    typedef enum logic [2:0] {
        OP_OPEN_COUNTED = 3'd0,
        OP_OPEN_REPEAT  = 3'd1,
        OP_CHECK_COUNTED = 3'd2,
        OP_CHECK_REPEAT = 3'd3,
        OP_CLOSE        = 3'd4
    } t_op;

    // Fault codes reported with each result beat.
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_EMPTY = 2'd1;
    localparam logic [1:0] FAULT_FULL  = 2'd2;

    localparam int unsigned WORD_W = 32;

    typedef logic [WORD_W-1:0] t_word;

    // One loop entry on the stack.
    typedef struct packed {
        t_word counter;
        t_word start;
        t_word finish;
        t_word step;
    } t_entry;

endpackage

// ===== hw/rtl/loop_counter_stack_unit.sv =====
`timescale 1ns / 1ps
// An accepted beat is held in the input beat register and then moves to the result beat register.
// Throughput: one beat per cycle; the only limit is the output handshake backing up.
// The top stack entry is read and updated in the same cycle, so checks follow back to back.
// Reset (synchronous, active low) empties the stack and clears the valid bits of both beat registers.
// Stack entries are not cleared; an entry is always written by a push before it is read.
module loop_counter_stack_unit #(
    parameter int LOOP_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [2:0]          i_op,
    input  lcs_pkg::t_word      i_from_value,
    input  lcs_pkg::t_word      i_to_value,
    input  lcs_pkg::t_word      i_step_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_continue_loop,
    output lcs_pkg::t_word      o_loop_value,
    output logic [1:0]          o_fault
);
    import lcs_pkg::*;

    localparam int DEPTH_W = $clog2(LOOP_DEPTH + 1);
    localparam int IDX_W   = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(LOOP_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

    // Input beat register.
    logic               r_in_valid;
    logic [2:0]         r_op;
    t_word              r_from;
    t_word              r_to;
    t_word              r_step;

    // Result beat register.
    logic               r_out_valid;
    logic               r_cont;
    t_word              r_value;
    logic [1:0]         r_fault;

    // Stack storage and fill level.
    t_entry             r_stack [LOOP_DEPTH];
    logic [DEPTH_W-1:0] r_depth;

    logic               advance;
    logic [DEPTH_W-1:0] n_depth;
    logic               n_cont;
    t_word              n_value;
    logic [1:0]         n_fault;
    logic               do_push;
    logic               do_write_top;
    t_entry             push_entry;
    t_word              top_counter;
    logic [DEPTH_W-1:0] top_full;
    logic [IDX_W-1:0]   top_idx;
    logic [IDX_W-1:0]   push_idx;
    t_entry             top_entry;
    t_word              sum;
    logic               is_empty;
    logic               is_full;

    // The held beat moves to the result register when that register is free or being drained.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign is_empty = (r_depth == '0);
    assign is_full  = (r_depth == DEPTH_MAX);
    assign top_full = r_depth - DEPTH_ONE;
    assign top_idx  = top_full[IDX_W-1:0];
    assign push_idx = r_depth[IDX_W-1:0];
    assign top_entry = r_stack[top_idx];
    assign sum = top_entry.counter + top_entry.step;

    // Decode the held beat against the top entry.
    always_comb begin
        n_depth      = r_depth;
        n_cont       = 1'b0;
        n_value      = '0;
        n_fault      = FAULT_NONE;
        do_push      = 1'b0;
        do_write_top = 1'b0;
        top_counter  = top_entry.counter;
        push_entry   = '{counter: r_from - r_step, start: r_from, finish: r_to, step: r_step};
        case (r_op)
            OP_OPEN_COUNTED: begin
                if (is_full) begin
                    n_fault = FAULT_FULL;
                end else begin
                    do_push = 1'b1;
                    n_depth = r_depth + DEPTH_ONE;
                end
            end
            OP_OPEN_REPEAT: begin
                push_entry = '{counter: r_from, start: '0, finish: '0, step: '0};
                if (is_full) begin
                    n_fault = FAULT_FULL;
                end else begin
                    do_push = 1'b1;
                    n_depth = r_depth + DEPTH_ONE;
                end
            end
            OP_CHECK_COUNTED: begin
                if (is_empty) begin
                    n_fault = FAULT_EMPTY;
                end else begin
                    top_counter  = sum;
                    do_write_top = 1'b1;
                    n_value      = sum;
                    if (!top_entry.step[WORD_W-1]) begin
                        n_cont = ($signed(top_entry.start) <= $signed(sum)) &&
                                 ($signed(sum) <= $signed(top_entry.finish));
                    end else begin
                        n_cont = ($signed(top_entry.finish) <= $signed(sum)) &&
                                 ($signed(sum) <= $signed(top_entry.start));
                    end
                end
            end
            OP_CHECK_REPEAT: begin
                if (is_empty) begin
                    n_fault = FAULT_EMPTY;
                end else begin
                    // Only a positive count is decremented.
                    if (!top_entry.counter[WORD_W-1] && (top_entry.counter != '0)) begin
                        top_counter = top_entry.counter - t_word'(1);
                        n_cont      = 1'b1;
                    end
                    do_write_top = 1'b1;
                    n_value      = top_counter;
                end
            end
            OP_CLOSE: begin
                if (!is_empty) begin
                    n_depth = r_depth - DEPTH_ONE;
                end
            end
            default: begin
                n_depth = r_depth;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_depth     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_depth     <= n_depth;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op   <= i_op;
            r_from <= i_from_value;
            r_to   <= i_to_value;
            r_step <= i_step_value;
        end
        if (advance) begin
            r_cont  <= n_cont;
            r_value <= n_value;
            r_fault <= n_fault;
        end
    end

    // Stack writes: a push fills the free slot, a check updates the top counter.
    always_ff @(posedge i_clk) begin
        if (advance && do_push) begin
            r_stack[push_idx] <= push_entry;
        end
        if (advance && do_write_top) begin
            r_stack[top_idx].counter <= top_counter;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_continue_loop = r_cont;
    assign o_loop_value    = r_value;
    assign o_fault         = r_fault;

endmodule

// ===== hw/rtl/lcs_checker.sv =====
`timescale 1ns / 1ps

module lcs_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           o_in_ready,
    input  logic           o_out_valid,
    input  logic           i_out_ready,
    input  logic           o_continue_loop,
    input  lcs_pkg::t_word o_loop_value,
    input  logic [1:0]     o_fault
);
    import lcs_pkg::*;

    // A result beat that is not taken stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_loop_value)
            && $stable(o_fault) && $stable(o_continue_loop))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A faulted beat never reports a running loop or a counter value.
    a_fault_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_fault != FAULT_NONE) |-> !o_continue_loop && (o_loop_value == '0))
        else $error("faulted beat carries loop data");

    // Only the defined fault codes appear.
    a_fault_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fault == FAULT_NONE) || (o_fault == FAULT_EMPTY)
            || (o_fault == FAULT_FULL))
        else $error("undefined fault code");

    // With the output side free, the input side is never held off.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind loop_counter_stack_unit lcs_checker u_lcs_checker (.*);
